// File: rtl/bdc_pkg.sv
// package for the bezier evaluator: widths, types and arithmetic helpers
`default_nettype none
package bdc_pkg;
    localparam int MaxPoints = 16;
    localparam int TFracBits = 16;
    localparam int IdxW = 4;
    localparam int CntW = 5;
    localparam int CoordW = 32;
    localparam int OutW = 48;
    localparam int TW = 17;

    typedef enum logic [0:0] {
        ACT_WRITE = 1'b0,
        ACT_EVAL  = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [2:0][CoordW-1:0] pt;
    } t_point;

    // one rounding interpolation step; for t up to 1.0 the result stays between a and b
    function automatic logic signed [CoordW-1:0] lerp(
        input logic signed [CoordW-1:0] a,
        input logic signed [CoordW-1:0] b,
        input logic [TW-1:0] t
    );
        logic signed [CoordW:0] d;
        logic signed [CoordW+TW+1:0] p;
        logic [CoordW+1:0] q;
        begin
            d = $signed({b[CoordW-1], b}) - $signed({a[CoordW-1], a});
            p = d * $signed({1'b0, t}) + (CoordW+TW+2)'(1 << (TFracBits-1));
            q = p[TFracBits+CoordW+1:TFracBits];
            lerp = CoordW'(q + {{2{a[CoordW-1]}}, a});
        end
    endfunction

    function automatic logic signed [OutW-1:0] sat48(input logic signed [63:0] v);
        logic signed [63:0] mx;
        logic signed [63:0] mn;
        begin
            mx = (64'sd1 <<< (OutW-1)) - 64'sd1;
            mn = -(64'sd1 <<< (OutW-1));
            if (v > mx) sat48 = mx[OutW-1:0];
            else if (v < mn) sat48 = mn[OutW-1:0];
            else sat48 = v[OutW-1:0];
        end
    endfunction
endpackage
`default_nettype wire

// File: rtl/bdc_if.sv
// valid/ready channel interfaces for input and result items
`default_nettype none
interface bdc_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [3:0]  point_index;
    logic [31:0] point_x;
    logic [31:0] point_y;
    logic [31:0] point_z;
    logic [16:0] param_t;
    modport source(output valid, action, point_index, point_x, point_y, point_z, param_t,
                   input ready);
    modport sink(input valid, action, point_index, point_x, point_y, point_z, param_t,
                 output ready);
endinterface

interface bdc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [47:0] slope_x;
    logic [47:0] slope_y;
    logic [47:0] slope_z;
    logic [47:0] bend_x;
    logic [47:0] bend_y;
    logic [47:0] bend_z;
    modport source(output valid, pos_x, pos_y, pos_z, slope_x, slope_y, slope_z,
                   bend_x, bend_y, bend_z, input ready);
    modport sink(input valid, pos_x, pos_y, pos_z, slope_x, slope_y, slope_z,
                 bend_x, bend_y, bend_z, output ready);
endinterface
`default_nettype wire

// File: rtl/bdc_ram.sv
// dual port point memory, one write and one registered read
`default_nettype none
module bdc_ram (
    input  wire logic                  i_clk,
    input  wire logic                  i_we,
    input  wire logic [bdc_pkg::IdxW-1:0] i_waddr,
    input  wire bdc_pkg::t_point       i_wdata,
    input  wire logic [bdc_pkg::IdxW-1:0] i_raddr,
    output bdc_pkg::t_point            o_rdata
);
    import bdc_pkg::*;
    t_point mem [MaxPoints];
    t_point r_rdata;
    always_ff @(posedge i_clk) begin
        if (i_we) mem[i_waddr] <= i_wdata;
        r_rdata <= mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// File: rtl/bezier_de_casteljau_eval.sv
// top level: control point store and de casteljau sequencer
// write item: taken while idle, the next item can follow at once
// evaluate item with n points: a level of m points takes m reads plus one drain state;
// no new item is taken until the result has moved to the output register;
// a finished result waits in the output register
// reset clears point_count and control; the point store is undefined until written
`default_nettype none
module bezier_de_casteljau_eval (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [4:0] i_cfg_wdata,
    bdc_in_if.sink          i_in,
    bdc_out_if.source       o_out
);
    import bdc_pkg::*;

    t_state r_state, n_state;
    logic r_valid, n_valid;
    logic [CntW-1:0] r_count;
    logic [CntW-1:0] r_n;
    logic [CntW-1:0] r_m;      // points left at this level
    logic [IdxW-1:0] r_i;      // read index in level
    logic [TW-1:0]   r_t;
    logic            r_first;  // first level reads the point store
    logic            r_rd_vld;
    logic [IdxW-1:0] r_rd_idx;
    logic signed [CoordW-1:0] r_prev [3];
    logic signed [CoordW-1:0] r_w0 [3];
    logic signed [CoordW-1:0] r_w1 [3];
    logic [CoordW-1:0] r_pos [3];
    logic [OutW-1:0]   r_slope [3];
    logic [OutW-1:0]   r_bend [3];
    logic [CoordW-1:0] r_o_pos [3];
    logic [OutW-1:0]   r_o_slope [3];
    logic [OutW-1:0]   r_o_bend [3];

    logic in_ready;
    logic in_fire;
    logic eval_fire;
    logic pt_we;
    logic rd_en;
    logic done_fire;
    logic level_last;
    logic work_we;
    logic [IdxW-1:0] work_waddr;
    t_point pt_rd;
    t_point work_rd;
    t_point lerped;
    logic signed [CoordW-1:0] cur [3];
    logic [CntW-1:0] deg;
    logic [2*CntW-1:0] coef2;
    logic signed [CoordW:0] diff1 [3];
    logic signed [CoordW+2:0] diff2 [3];
    logic signed [CoordW+CntW+1:0] slope_full [3];
    logic signed [CoordW+2*CntW+3:0] bend_full [3];

    assign in_fire = i_in.valid && in_ready;
    assign eval_fire = in_fire && (i_in.action == ACT_EVAL);
    assign pt_we = in_fire && (i_in.action == ACT_WRITE);
    assign level_last = (CntW'(r_i) == r_m - CntW'(1));
    assign work_we = r_rd_vld && (r_rd_idx != '0);
    assign work_waddr = r_rd_idx - IdxW'(1);

    bdc_ram u_points (
        .i_clk  (i_clk),
        .i_we   (pt_we),
        .i_waddr(i_in.point_index),
        .i_wdata({i_in.point_z, i_in.point_y, i_in.point_x}),
        .i_raddr(r_i),
        .o_rdata(pt_rd)
    );

    bdc_ram u_work (
        .i_clk  (i_clk),
        .i_we   (work_we),
        .i_waddr(work_waddr),
        .i_wdata(lerped),
        .i_raddr(r_i),
        .o_rdata(work_rd)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (eval_fire) n_state = (r_count == '0) ? ST_DONE : ST_READ;
            end
            ST_READ: begin
                if (level_last) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                n_state = (r_m == CntW'(1)) ? ST_DONE : ST_READ;
            end
            ST_DONE: begin
                if (done_fire) n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        in_ready = 1'b0;
        rd_en = 1'b0;
        done_fire = 1'b0;
        unique case (r_state)
            ST_IDLE: in_ready = 1'b1;
            ST_READ: rd_en = 1'b1;
            ST_DRAIN: in_ready = 1'b0;
            ST_DONE: done_fire = !r_valid || o_out.ready;
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        if (o_out.valid && o_out.ready) n_valid = 1'b0;
        if (done_fire) n_valid = 1'b1;
    end

    always_comb begin
        deg = r_n - CntW'(1);
        coef2 = (2*CntW)'(deg) * ((2*CntW)'(deg) - (2*CntW)'(1));
        for (int k = 0; k < 3; k++) begin
            cur[k] = r_first ? $signed(pt_rd.pt[k]) : $signed(work_rd.pt[k]);
            lerped.pt[k] = lerp(r_prev[k], cur[k], r_t);
            diff1[k] = $signed({cur[k][CoordW-1], cur[k]})
                     - $signed({r_w0[k][CoordW-1], r_w0[k]});
            diff2[k] = $signed({{3{cur[k][CoordW-1]}}, cur[k]})
                     - $signed({{2{r_w1[k][CoordW-1]}}, r_w1[k], 1'b0})
                     + $signed({{3{r_w0[k][CoordW-1]}}, r_w0[k]});
            slope_full[k] = $signed({1'b0, deg}) * diff1[k];
            bend_full[k] = $signed({1'b0, coef2}) * diff2[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
            r_count <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            if (i_cfg_we) r_count <= i_cfg_wdata;
            r_rd_vld <= rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eval_fire) begin
            r_n <= (r_count > CntW'(MaxPoints)) ? CntW'(MaxPoints) : r_count;
            r_m <= (r_count > CntW'(MaxPoints)) ? CntW'(MaxPoints) : r_count;
            r_t <= (i_in.param_t > TW'(1 << TFracBits)) ? TW'(1 << TFracBits)
                                                         : i_in.param_t;
            r_i <= '0;
            r_first <= 1'b1;
            for (int k = 0; k < 3; k++) begin
                r_pos[k] <= '0;
                r_slope[k] <= '0;
                r_bend[k] <= '0;
            end
        end
        if (rd_en) begin
            r_rd_idx <= r_i;
            r_i <= level_last ? '0 : r_i + IdxW'(1);
        end
        if (r_rd_vld) begin
            for (int k = 0; k < 3; k++) begin
                r_prev[k] <= cur[k];
                if (r_rd_idx == IdxW'(0)) r_w0[k] <= cur[k];
                if (r_rd_idx == IdxW'(1)) r_w1[k] <= cur[k];
            end
        end
        if (r_state == ST_DRAIN) begin
            if (r_m != CntW'(1)) begin
                r_m <= r_m - CntW'(1);
                r_first <= 1'b0;
            end
            for (int k = 0; k < 3; k++) begin
                if (r_m == CntW'(3)) r_bend[k] <= sat48(64'(bend_full[k]));
                if (r_m == CntW'(2)) r_slope[k] <= sat48(64'(slope_full[k]));
                if (r_m == CntW'(1)) r_pos[k] <= cur[k];
            end
        end
        if (done_fire) begin
            for (int k = 0; k < 3; k++) begin
                r_o_pos[k] <= r_pos[k];
                r_o_slope[k] <= r_slope[k];
                r_o_bend[k] <= r_bend[k];
            end
        end
    end

    assign i_in.ready = in_ready;
    assign o_out.valid = r_valid;
    assign o_out.pos_x = r_o_pos[0];
    assign o_out.pos_y = r_o_pos[1];
    assign o_out.pos_z = r_o_pos[2];
    assign o_out.slope_x = r_o_slope[0];
    assign o_out.slope_y = r_o_slope[1];
    assign o_out.slope_z = r_o_slope[2];
    assign o_out.bend_x = r_o_bend[0];
    assign o_out.bend_y = r_o_bend[1];
    assign o_out.bend_z = r_o_bend[2];
endmodule
`default_nettype wire
